### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every rising edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// The condition must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

### hw/rtl/ggs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ggs_pkg;

	localparam int DEFAULT_MAX_GROUP = 65536;
	localparam int DEFAULT_FRAC_BITS = 16;

	// Depth of the group queue between the counting front and the divider back.
	localparam int QUEUE_DEPTH = 4;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// Register index of minor_fold (byte address 4 * index).
	localparam logic [0:0] REG_MINOR_FOLD = 1'b0;

	localparam logic [7:0] GT_MISSING = 8'h00;
	localparam logic [7:0] GT_HOM     = 8'h01;
	localparam logic [7:0] GT_HET     = 8'h02;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AF_GO,
		ST_AF_WAIT,
		ST_HET_GO,
		ST_HET_WAIT,
		ST_MISS_GO,
		ST_MISS_WAIT,
		ST_OUT
	} back_state_t;

endpackage

`default_nettype wire

### hw/rtl/ggs_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ggs_front #(
	parameter int MAX_GROUP = ggs_pkg::DEFAULT_MAX_GROUP,
	parameter int CNT_W     = $clog2(MAX_GROUP + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           genotype_code,
	input  logic                 last_in_group,
	output logic                 q_wr,
	output logic [4*CNT_W:0]     q_wdata
);
	import ggs_pkg::*;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_GROUP);

	logic [CNT_W-1:0] missing_q, het_q, total_q;
	logic [CNT_W:0]   half_q;
	logic [CNT_W-1:0] missing_nxt, het_nxt, total_nxt;
	logic [CNT_W:0]   half_nxt;

	// Counts including the current beat; items past the group limit are not counted.
	always_comb begin
		missing_nxt = missing_q;
		het_nxt     = het_q;
		total_nxt   = total_q;
		half_nxt    = half_q;
		if (total_q < MAX_CNT) begin
			total_nxt = total_q + 1'b1;
			case (genotype_code)
				GT_MISSING: missing_nxt = missing_q + 1'b1;
				GT_HOM:     half_nxt = half_q + (CNT_W + 1)'(2);
				GT_HET: begin
					half_nxt = half_q + 1'b1;
					het_nxt  = het_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign q_wr    = accept && last_in_group;
	assign q_wdata = {missing_nxt, half_nxt, het_nxt, total_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			missing_q <= '0;
			het_q     <= '0;
			total_q   <= '0;
			half_q    <= '0;
		end else if (accept) begin
			if (last_in_group) begin
				missing_q <= '0;
				het_q     <= '0;
				total_q   <= '0;
				half_q    <= '0;
			end else begin
				missing_q <= missing_nxt;
				het_q     <= het_nxt;
				total_q   <= total_nxt;
				half_q    <= half_nxt;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/ggs_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ggs_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = ggs_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full  = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign rdata = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/ggs_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider for (num << FRAC_BITS) / den with num <= den, one quotient bit a cycle.
module ggs_div #(
	parameter int W         = 18,
	parameter int FRAC_BITS = ggs_pkg::DEFAULT_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [W-1:0]       num,
	input  logic [W-1:0]       den,
	output logic               busy,
	output logic               done,
	output logic [FRAC_BITS:0] quo
);
	localparam int CW = $clog2(FRAC_BITS + 2);
	localparam logic [CW-1:0] STEPS = CW'(FRAC_BITS + 1);

	logic [W:0]         rem_q, diff;
	logic [W-1:0]       den_q;
	logic [FRAC_BITS:0] quo_q;
	logic [CW-1:0]      cnt_q;
	logic               busy_q, done_q, den_zero_q;
	logic               ge;

	assign ge   = (rem_q >= {1'b0, den_q});
	assign diff = ge ? (rem_q - {1'b0, den_q}) : rem_q;

	assign busy = busy_q;
	assign done = done_q;
	// A zero divisor only arises for an empty denominator, which reports zero.
	assign quo  = den_zero_q ? '0 : quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q      <= {1'b0, num};
			den_q      <= den;
			den_zero_q <= (den == '0);
		end else if (busy_q) begin
			rem_q <= {diff[W-1:0], 1'b0};
			quo_q <= {quo_q[FRAC_BITS-1:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= STEPS;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/ggs_back.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ggs_back #(
	parameter int MAX_GROUP = ggs_pkg::DEFAULT_MAX_GROUP,
	parameter int FRAC_BITS = ggs_pkg::DEFAULT_FRAC_BITS,
	parameter int CNT_W     = $clog2(MAX_GROUP + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               minor_fold,
	input  logic [4*CNT_W:0]   q_rdata,
	input  logic               q_empty,
	output logic               q_rd,
	input  logic               pop,
	output logic               empty,
	output logic [FRAC_BITS:0] allele_freq,
	output logic [FRAC_BITS:0] het_freq,
	output logic [FRAC_BITS:0] missing_freq,
	output logic               all_missing
);
	import ggs_pkg::*;

	localparam int DW = CNT_W + 1;

	back_state_t state_q, state_nxt;

	logic [CNT_W-1:0] e_total, e_het, e_miss, e_present;
	logic [CNT_W:0]   e_half, e_twice, af_num;
	logic             fold;

	logic [CNT_W-1:0] present_q, het_q, miss_q, total_q;
	logic [DW-1:0]    af_num_q;
	logic [FRAC_BITS:0] af_res_q, het_res_q, miss_res_q;

	logic               div_start, div_busy, div_done;
	logic [DW-1:0]      div_num, div_den;
	logic [FRAC_BITS:0] div_quo;
	logic               out_load;

	logic               out_valid_q, out_all_missing_q;
	logic [FRAC_BITS:0] out_af_q, out_het_q, out_miss_q;

	assign e_total   = q_rdata[CNT_W-1:0];
	assign e_het     = q_rdata[2*CNT_W-1:CNT_W];
	assign e_half    = q_rdata[3*CNT_W:2*CNT_W];
	assign e_miss    = q_rdata[4*CNT_W:3*CNT_W+1];
	assign e_present = e_total - e_miss;
	assign e_twice   = {e_present, 1'b0};
	// Fold only when the frequency is strictly above one half.
	assign fold      = minor_fold && (e_half > {1'b0, e_present});
	assign af_num    = fold ? (e_twice - e_half) : e_half;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:      if (!q_empty) state_nxt = ST_AF_GO;
			ST_AF_GO:     state_nxt = ST_AF_WAIT;
			ST_AF_WAIT:   if (div_done) state_nxt = ST_HET_GO;
			ST_HET_GO:    state_nxt = ST_HET_WAIT;
			ST_HET_WAIT:  if (div_done) state_nxt = ST_MISS_GO;
			ST_MISS_GO:   state_nxt = ST_MISS_WAIT;
			ST_MISS_WAIT: if (div_done) state_nxt = ST_OUT;
			ST_OUT:       if (!out_valid_q || pop) state_nxt = ST_IDLE;
			default:      state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		q_rd      = 1'b0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: q_rd = !q_empty;
			ST_AF_GO: begin
				div_start = 1'b1;
				div_num   = af_num_q;
				div_den   = {present_q, 1'b0};
			end
			ST_HET_GO: begin
				div_start = 1'b1;
				div_num   = {1'b0, het_q};
				div_den   = {1'b0, present_q};
			end
			ST_MISS_GO: begin
				div_start = 1'b1;
				div_num   = {1'b0, miss_q};
				div_den   = {1'b0, total_q};
			end
			ST_OUT:  out_load = !out_valid_q || pop;
			default: ;
		endcase
	end

	ggs_div #(
		.W         (DW),
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			present_q <= e_present;
			het_q     <= e_het;
			miss_q    <= e_miss;
			total_q   <= e_total;
			af_num_q  <= af_num;
		end
		if (div_done && state_q == ST_AF_WAIT) begin
			af_res_q <= div_quo;
		end
		if (div_done && state_q == ST_HET_WAIT) begin
			het_res_q <= div_quo;
		end
		if (div_done && state_q == ST_MISS_WAIT) begin
			miss_res_q <= div_quo;
		end
		if (out_load) begin
			out_af_q          <= af_res_q;
			out_het_q         <= het_res_q;
			out_miss_q        <= miss_res_q;
			out_all_missing_q <= (present_q == '0);
		end
	end

	assign empty        = !out_valid_q;
	assign allele_freq  = out_af_q;
	assign het_freq     = out_het_q;
	assign missing_freq = out_miss_q;
	assign all_missing  = out_all_missing_q;

	`ASSERT_HOLDS(a_start_busy, clk, arst_n, div_start |=> div_busy, "divider did not start")
	`ASSERT_NEVER(a_pop_busy, clk, arst_n, q_rd && state_q != ST_IDLE, "queue read while busy")
	`ASSERT_HOLDS(a_out_hold, clk, arst_n, (state_q == ST_OUT && out_valid_q && !pop) |=> state_q == ST_OUT, "result overwritten before it was taken")
	`ASSERT_HOLDS(a_all_missing_zero, clk, arst_n, (out_valid_q && out_all_missing_q) |-> (out_af_q == '0 && out_het_q == '0), "all-missing group with non-zero fractions")

endmodule

`default_nettype wire

### hw/rtl/genotype_group_statistics.sv
// Throughput: one genotype beat per cycle while the group queue has room.
// Groups are divided one at a time on the shared one-bit-a-cycle divider.
// Reset: arst_n is asynchronous and active low; it clears the counters, queue, result flag and
// minor_fold. No clearing pass is needed, so the block takes beats straight after reset.
`timescale 1ns / 1ps
`default_nettype none

module genotype_group_statistics #(
	parameter int MAX_GROUP = ggs_pkg::DEFAULT_MAX_GROUP,
	parameter int FRAC_BITS = ggs_pkg::DEFAULT_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration port.
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ggs_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [ggs_pkg::APB_DATA_W-1:0] pwdata,
	output logic [ggs_pkg::APB_DATA_W-1:0] prdata,
	output logic                          pready,
	// Genotype beats in.
	input  logic                          push,
	output logic                          full,
	input  logic [7:0]                    genotype_code,
	input  logic                          last_in_group,
	// Group results out.
	input  logic                          pop,
	output logic                          empty,
	output logic [FRAC_BITS:0]            allele_freq,
	output logic [FRAC_BITS:0]            het_freq,
	output logic [FRAC_BITS:0]            missing_freq,
	output logic                          all_missing
);
	import ggs_pkg::*;

	// The counters must hold MAX_GROUP itself; the half-allele count needs one bit more.
	localparam int CNT_W   = $clog2(MAX_GROUP + 1);
	localparam int ENTRY_W = 4 * CNT_W + 1;

	logic               minor_fold_q;
	logic               reg_hit;
	logic               accept;
	logic               q_wr, q_rd, q_full, q_empty;
	logic [ENTRY_W-1:0] q_wdata, q_rdata;

	// The register index is the word address; the low two byte-address bits are ignored.
	// Only minor_fold exists, so any other index reads as zero and ignores writes.
	assign reg_hit = (paddr[2:2] == REG_MINOR_FOLD);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? {{(APB_DATA_W - 1){1'b0}}, minor_fold_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			minor_fold_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			minor_fold_q <= pwdata[0];
		end
	end

	// The front counts every accepted beat up to the group limit. The beat that closes a group
	// is counted first and the finished counts go into the group queue in that same cycle,
	// so the counters start the next group without a gap. The front only stalls when the
	// queue is full, which happens with a run of very short groups or when results are not
	// being taken.
	assign full   = q_full;
	assign accept = push && !q_full;

	ggs_front #(
		.MAX_GROUP (MAX_GROUP),
		.CNT_W     (CNT_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.genotype_code (genotype_code),
		.last_in_group (last_in_group),
		.q_wr          (q_wr),
		.q_wdata       (q_wdata)
	);

	ggs_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.full   (q_full),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	// The back takes one group at a time and runs three divisions on one shared divider:
	// allele frequency (folded to the minor allele if asked), heterozygous share and missing
	// share. The result sits in an output register until popped, and the back may already
	// be dividing the next group while it waits there.
	ggs_back #(
		.MAX_GROUP (MAX_GROUP),
		.FRAC_BITS (FRAC_BITS),
		.CNT_W     (CNT_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.minor_fold   (minor_fold_q),
		.q_rdata      (q_rdata),
		.q_empty      (q_empty),
		.q_rd         (q_rd),
		.pop          (pop),
		.empty        (empty),
		.allele_freq  (allele_freq),
		.het_freq     (het_freq),
		.missing_freq (missing_freq),
		.all_missing  (all_missing)
	);

endmodule

`default_nettype wire

### sim/genotype_group_statistics_checker.sv
`timescale 1ns / 1ps

module genotype_group_statistics_checker #(
	parameter int MAX_GROUP = ggs_pkg::DEFAULT_MAX_GROUP,
	parameter int FRAC_BITS = ggs_pkg::DEFAULT_FRAC_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ggs_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [ggs_pkg::APB_DATA_W-1:0] pwdata,
	input  logic [ggs_pkg::APB_DATA_W-1:0] prdata,
	input  logic                           pready,
	input  logic                           push,
	input  logic                           full,
	input  logic [7:0]                     genotype_code,
	input  logic                           last_in_group,
	input  logic                           pop,
	input  logic                           empty,
	input  logic [FRAC_BITS:0]             allele_freq,
	input  logic [FRAC_BITS:0]             het_freq,
	input  logic [FRAC_BITS:0]             missing_freq,
	input  logic                           all_missing,
	output int                             fail_count,
	output int                             outstanding
);

	localparam logic [ggs_pkg::APB_ADDR_W-1:0] FOLD_ADDR = {ggs_pkg::REG_MINOR_FOLD, 2'b00};

	typedef struct {
		logic [FRAC_BITS:0] allele;
		logic [FRAC_BITS:0] het;
		logic [FRAC_BITS:0] missing;
		logic               none_present;
	} group_stats_t;

	int unsigned  n_missing;
	int unsigned  n_half;
	int unsigned  n_het;
	int unsigned  n_total;
	logic         fold_minor;
	int           mismatches = 0;
	group_stats_t awaited_stats[$];

	assign fail_count = mismatches;

	task automatic report(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// Truncated fraction with FRAC_BITS fraction bits, kept to FRAC_BITS + 1 bits.
	function automatic logic [FRAC_BITS:0] q_fraction(input longint unsigned num,
			input longint unsigned den);
		longint unsigned q;
		if (den == 0)
			return '0;
		q = (num << FRAC_BITS) / den;
		return q[FRAC_BITS:0];
	endfunction

	function automatic group_stats_t group_summary();
		longint unsigned present;
		longint unsigned twice;
		group_stats_t    s;
		present = n_total - n_missing;
		twice = 2 * present;
		s.missing = q_fraction(n_missing, n_total);
		if (present == 0) begin
			s.allele = '0;
			s.het = '0;
			s.none_present = 1'b1;
		end else begin
			// Fold only when strictly above one half.
			if (fold_minor && n_half > present)
				s.allele = q_fraction(twice - n_half, twice);
			else
				s.allele = q_fraction(n_half, twice);
			s.het = q_fraction(n_het, present);
			s.none_present = 1'b0;
		end
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		group_stats_t want;
		if (!arst_n) begin
			n_missing = 0;
			n_half = 0;
			n_het = 0;
			n_total = 0;
			fold_minor = 1'b0;
			awaited_stats.delete();
			outstanding <= 0;
		end else begin
			if (psel && penable && pready && paddr == FOLD_ADDR) begin
				if (pwrite)
					fold_minor = pwdata[0];
				else if (prdata !== {{(ggs_pkg::APB_DATA_W-1){1'b0}}, fold_minor})
					report($sformatf("minor_fold read %0h, expected %0d", prdata, fold_minor));
			end

			if (pop && !empty) begin
				if (awaited_stats.size() == 0) begin
					report("result beat with no group closed");
				end else begin
					want = awaited_stats.pop_front();
					if (allele_freq !== want.allele)
						report($sformatf("allele_freq %0d, expected %0d",
							allele_freq, want.allele));
					if (het_freq !== want.het)
						report($sformatf("het_freq %0d, expected %0d", het_freq, want.het));
					if (missing_freq !== want.missing)
						report($sformatf("missing_freq %0d, expected %0d",
							missing_freq, want.missing));
					if (all_missing !== want.none_present)
						report($sformatf("all_missing %0d, expected %0d",
							all_missing, want.none_present));
				end
			end

			if (push && !full) begin
				// Beats past the group size limit are not counted but can still close it.
				if (n_total < MAX_GROUP) begin
					n_total++;
					case (genotype_code)
						ggs_pkg::GT_MISSING: n_missing++;
						ggs_pkg::GT_HOM: n_half += 2;
						ggs_pkg::GT_HET: begin
							n_half++;
							n_het++;
						end
						default: ;
					endcase
				end
				if (last_in_group) begin
					awaited_stats.push_back(group_summary());
					n_missing = 0;
					n_half = 0;
					n_het = 0;
					n_total = 0;
				end
			end
			outstanding <= awaited_stats.size();
		end
	end

endmodule

### sim/genotype_group_statistics_test.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the genotype group statistics block. The checker beside the block
// follows every genotype beat and every result beat and keeps the running tally of failures;
// this module only makes traffic, writes and reads back the minor_fold register between
// phases and decides the outcome once all expected group results have come back.
module genotype_group_statistics_test;

	import ggs_pkg::*;

	localparam int MAX_GROUP = DEFAULT_MAX_GROUP;
	localparam int FRAC_BITS = DEFAULT_FRAC_BITS;
	localparam logic [APB_ADDR_W-1:0] FOLD_ADDR = {REG_MINOR_FOLD, 2'b00};

	// Quiet spell at the end of each drain, after every expected result has come back.
	localparam int SETTLE_CYCLES = 80;
	localparam int HOLD_CYCLES = 400;
	localparam int ITEMS_PER_PHASE = 312;
	localparam int CYCLE_LIMIT = 1500000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  push = 1'b0;
	logic                  full;
	logic [7:0]            genotype_code = '0;
	logic                  last_in_group = 1'b0;
	logic                  pop = 1'b0;
	logic                  empty;
	logic [FRAC_BITS:0]    allele_freq;
	logic [FRAC_BITS:0]    het_freq;
	logic [FRAC_BITS:0]    missing_freq;
	logic                  all_missing;

	int fail_count;
	int outstanding;
	int cycles = 0;

	// Idling is switched off for the final phase so that back-to-back traffic is seen as well.
	logic idle_on = 1'b1;
	int   holds_asked = 0;
	int   holds_served = 0;
	int   stall_left = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	genotype_group_statistics #(
		.MAX_GROUP(MAX_GROUP),
		.FRAC_BITS(FRAC_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.push(push),
		.full(full),
		.genotype_code(genotype_code),
		.last_in_group(last_in_group),
		.pop(pop),
		.empty(empty),
		.allele_freq(allele_freq),
		.het_freq(het_freq),
		.missing_freq(missing_freq),
		.all_missing(all_missing)
	);

	genotype_group_statistics_checker #(
		.MAX_GROUP(MAX_GROUP),
		.FRAC_BITS(FRAC_BITS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.push(push),
		.full(full),
		.genotype_code(genotype_code),
		.last_in_group(last_in_group),
		.pop(pop),
		.empty(empty),
		.allele_freq(allele_freq),
		.het_freq(het_freq),
		.missing_freq(missing_freq),
		.all_missing(all_missing),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	// Guard against a hung block: the slowest legal run stays well below this count.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("genotype_group_statistics: mismatch");
			$finish;
		end
	end

	// Result side. Short random stalls while idling is on, and one long hold-off on request,
	// counted here, during which the sender keeps pushing until the block has to refuse beats.
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (holds_served != holds_asked) begin
			holds_served <= holds_asked;
			stall_left <= HOLD_CYCLES - 1;
			pop <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			pop <= 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 4);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// Offers one genotype beat and returns at the edge where it is taken. An idle gap, when
	// one is drawn, comes first, and the code lines carry noise while push is low. Inputs move
	// on falling edges; full is read straight after the rising edge, before it can update.
	task automatic send_beat(input logic [7:0] code, input logic last);
		int gap;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			genotype_code <= 8'($urandom_range(0, 255));
			last_in_group <= 1'($urandom_range(0, 1));
			gap = $urandom_range(1, 5);
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		genotype_code <= code;
		last_in_group <= last;
		do
			@(posedge clk);
		while (full);
	endtask

	// One group of random shape. Most groups are short; now and then a longer one comes.
	task automatic send_group(output int sent);
		int         len;
		int         style;
		int         k;
		int         r;
		logic [7:0] code;
		style = $urandom_range(0, 9);
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
		for (k = 0; k < len; k++) begin
			r = $urandom_range(0, 9);
			case (style)
				0: code = GT_MISSING;
				1: code = GT_HET;
				2: code = (r < 3) ? GT_HET : GT_HOM;
				3: code = 8'($urandom_range(0, 255));
				default: begin
					if (r < 3)
						code = GT_MISSING;
					else if (r < 6)
						code = GT_HOM;
					else if (r < 9)
						code = GT_HET;
					else
						code = 8'($urandom_range(0, 255));
				end
			endcase
			send_beat(code, k == len - 1);
		end
		sent = len;
	endtask

	// Lowers push, waits for every expected result, then waits for a quiet spell as well.
	task automatic drain_results();
		@(negedge clk);
		push <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic write, input logic [APB_DATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= FOLD_ADDR;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Writes minor_fold with random upper bits, which the register should ignore, and reads
	// it back so that the checker can compare the read data.
	task automatic set_minor_fold(input logic fold);
		logic [APB_DATA_W-1:0] data;
		data = $urandom;
		data[0] = fold;
		apb_access(1'b1, data);
		apb_access(1'b0, '0);
	endtask

	initial begin
		int phase;
		int sent;
		int n;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The register must read back as clear straight after reset.
		apb_access(1'b0, '0);

		// Directed groups with folding off (reset value). Single-beat groups give the extreme
		// values: a full allele frequency of one, an all-missing group, a pure heterozygote
		// and an uncounted code.
		send_beat(GT_HOM, 1'b1);
		send_beat(GT_MISSING, 1'b1);
		send_beat(GT_HET, 1'b1);
		send_beat(8'hFF, 1'b1);
		// Missing beats mixed with present ones, and the other codes that count nothing.
		send_beat(GT_MISSING, 1'b0);
		send_beat(GT_MISSING, 1'b0);
		send_beat(GT_HOM, 1'b1);
		send_beat(GT_HOM, 1'b0);
		send_beat(GT_HET, 1'b0);
		send_beat(8'h80, 1'b0);
		send_beat(8'h7F, 1'b0);
		send_beat(GT_MISSING, 1'b1);

		drain_results();
		set_minor_fold(1'b1);

		// With folding on: one homozygote folds down to zero, two heterozygotes sit exactly
		// at one half and must not fold, and a frequency of five sixths folds to one sixth.
		send_beat(GT_HOM, 1'b1);
		send_beat(GT_HET, 1'b0);
		send_beat(GT_HET, 1'b1);
		send_beat(GT_HOM, 1'b0);
		send_beat(GT_HOM, 1'b0);
		send_beat(GT_HET, 1'b1);
		send_beat(GT_MISSING, 1'b0);
		send_beat(GT_MISSING, 1'b0);
		send_beat(GT_MISSING, 1'b1);
		send_beat(GT_HOM, 1'b0);
		send_beat(8'h55, 1'b0);
		send_beat(8'hAA, 1'b1);

		drain_results();
		set_minor_fold(1'b0);

		// Random phases, each under its own fold setting. The second opens with the long
		// hold-off on the result side; the last runs with no idling on either side.
		for (phase = 0; phase < 4; phase++) begin
			drain_results();
			if (phase == 2)
				set_minor_fold(1'($urandom_range(0, 1)));
			else
				set_minor_fold(phase != 1);
			if (phase == 1)
				holds_asked = holds_asked + 1;
			if (phase == 3)
				idle_on = 1'b0;
			n = 0;
			while (n < ITEMS_PER_PHASE) begin
				send_group(sent);
				n += sent;
			end
		end

		drain_results();
		if (fail_count == 0)
			$display("genotype_group_statistics: match");
		else
			$display("genotype_group_statistics: mismatch");
		$finish;
	end

endmodule
